// ----- sv/pwq_pkg.sv -----
package pwq_pkg;

  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_APPEND   = 3'd1,
    CMD_REMOVE   = 3'd2,
    CMD_WAKE_ONE = 3'd3,
    CMD_WAKE_ALL = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_DUP       = 3'd4
  } status_t;

  // per-cycle control broadcast along the cell row
  typedef struct packed {
    logic ins_we;
    logic rem_we;
    logic append;
    logic by_id;
    logic pop;
  } cell_ctl_t;

endpackage

// ----- sv/pwq_if.sv -----
interface pwq_req_if #(
  parameter int ID_BITS   = 6,
  parameter int PRIO_BITS = 5
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           cmd;
  logic [ID_BITS-1:0]   thread_id;
  logic [PRIO_BITS-1:0] priority_req;

  modport source (output valid, cmd, thread_id, priority_req, input ready);
  modport sink   (input valid, cmd, thread_id, priority_req, output ready);
endinterface

interface pwq_rsp_if #(
  parameter int ID_BITS = 6,
  parameter int CNT_W   = 5
);
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [ID_BITS-1:0] woken_id;
  logic               woken_valid;
  logic [CNT_W-1:0]   entry_count;
  logic               last;

  modport source (output valid, status, woken_id, woken_valid, entry_count, last,
                  input ready);
  modport sink   (input valid, status, woken_id, woken_valid, entry_count, last,
                  output ready);
endinterface

// ----- sv/pwq_cell.sv -----
module pwq_cell #(
  parameter int ID_BITS   = 6,
  parameter int PRIO_BITS = 5,
  parameter int CNT_W     = 5,
  parameter int IDX       = 0
) (
  input  logic                  clk,
  input  logic [CNT_W-1:0]      occ,
  input  pwq_pkg::cell_ctl_t    ctl,
  input  logic [ID_BITS-1:0]    new_id,
  input  logic [PRIO_BITS-1:0]  new_prio,
  input  logic [ID_BITS-1:0]    left_id,
  input  logic [PRIO_BITS-1:0]  left_prio,
  input  logic [ID_BITS-1:0]    right_id,
  input  logic [PRIO_BITS-1:0]  right_prio,
  input  logic                  shift_i,
  input  logic                  le_any_i,
  input  logic                  pull_i,
  output logic                  shift_o,
  output logic                  le_any_o,
  output logic                  pull_o,
  output logic                  hit_o,
  output logic [ID_BITS-1:0]    id_o,
  output logic [PRIO_BITS-1:0]  prio_o
);

  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;
  logic                 live;
  logic                 le;

  assign live     = (CNT_W'(IDX) < occ);
  assign hit_o    = live && (id_r == new_id);
  // entry stays ahead of a new one unless it has strictly greater priority and the command is not an append
  assign le       = live && (ctl.append || !(prio_r > new_prio));
  assign le_any_o = le | le_any_i;
  assign shift_o  = !le_any_o;
  assign pull_o   = pull_i | (hit_o & ctl.by_id);
  assign id_o     = id_r;
  assign prio_o   = prio_r;

  always_comb begin
    id_nxt   = id_r;
    prio_nxt = prio_r;
    if (ctl.ins_we && shift_o) begin
      id_nxt   = shift_i ? left_id   : new_id;
      prio_nxt = shift_i ? left_prio : new_prio;
    end else if (ctl.rem_we && pull_o) begin
      id_nxt   = right_id;
      prio_nxt = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
  end

endmodule

// ----- sv/priority_wait_queue.sv -----
// Priority wait queue of thread IDs, ordered by ascending priority value.
// in_req  : request channel (valid/ready) carrying cmd, thread_id, priority_req.
// out_rsp : result channel (valid/ready) carrying status, woken_id,
//           woken_valid, entry_count and last.
// Entries sit in a row of cells; every cell compares its entry with the
// request, and the cells behind the insertion or removal point shift
// towards their left or right neighbour. A request is taken in the idle
// state and executed in the execute state once the output register is
// free; its result is registered there. Wake-all stays in execution and
// gives one result per cycle while the output is taken, one per entry.
// The output register holds a result until it is taken; while the receiver
// stalls, one further request is taken and then execution waits.
// Reset empties the queue and clears the output valid; no clearing pass.
module priority_wait_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 6,
  parameter int PRIO_BITS   = 5
) (
  input logic      clk,
  input logic      rst_n,
  pwq_req_if.sink  in_req,
  pwq_rsp_if.source out_rsp
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     occ_r, occ_nxt;
  logic [2:0]           cmd_r, cmd_nxt;
  logic [ID_BITS-1:0]   tid_r, tid_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;

  logic                 out_vld_r, out_vld_nxt;
  logic [2:0]           status_r, status_nxt;
  logic [ID_BITS-1:0]   woken_id_r, woken_id_nxt;
  logic                 woken_vld_r, woken_vld_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 last_r, last_nxt;

  pwq_pkg::cell_ctl_t   ctl;
  logic                 slot_free;
  logic                 any_hit;
  logic                 full;

  logic [ID_BITS-1:0]   cell_id   [QUEUE_DEPTH];
  logic [PRIO_BITS-1:0] cell_prio [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] hit;
  logic [QUEUE_DEPTH:0] shift_c;
  logic [QUEUE_DEPTH:0] le_c;
  logic [QUEUE_DEPTH:0] pull_c;

  assign shift_c[0]          = 1'b0;
  assign pull_c[0]           = ctl.pop;
  assign le_c[QUEUE_DEPTH]   = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0]   l_id, r_id;
    logic [PRIO_BITS-1:0] l_prio, r_prio;

    if (i == 0) begin : g_first
      assign l_id   = '0;
      assign l_prio = '0;
    end else begin : g_left
      assign l_id   = cell_id[i-1];
      assign l_prio = cell_prio[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign r_id   = '0;
      assign r_prio = '0;
    end else begin : g_right
      assign r_id   = cell_id[i+1];
      assign r_prio = cell_prio[i+1];
    end

    pwq_cell #(
      .ID_BITS   (ID_BITS),
      .PRIO_BITS (PRIO_BITS),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk        (clk),
      .occ        (occ_r),
      .ctl        (ctl),
      .new_id     (tid_r),
      .new_prio   (prio_r),
      .left_id    (l_id),
      .left_prio  (l_prio),
      .right_id   (r_id),
      .right_prio (r_prio),
      .shift_i    (shift_c[i]),
      .le_any_i   (le_c[i+1]),
      .pull_i     (pull_c[i]),
      .shift_o    (shift_c[i+1]),
      .le_any_o   (le_c[i]),
      .pull_o     (pull_c[i+1]),
      .hit_o      (hit[i]),
      .id_o       (cell_id[i]),
      .prio_o     (cell_prio[i])
    );
  end

  assign any_hit   = |hit;
  assign full      = (occ_r == CNT_W'(QUEUE_DEPTH));
  assign slot_free = !out_vld_r || out_rsp.ready;

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    cmd_nxt       = cmd_r;
    tid_nxt       = tid_r;
    prio_nxt      = prio_r;
    out_vld_nxt   = out_vld_r && !out_rsp.ready;
    status_nxt    = status_r;
    woken_id_nxt  = woken_id_r;
    woken_vld_nxt = woken_vld_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    ctl           = '0;
    ctl.append    = (cmd_r == pwq_pkg::CMD_APPEND);

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          cmd_nxt   = in_req.cmd;
          tid_nxt   = in_req.thread_id;
          prio_nxt  = in_req.priority_req;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          out_vld_nxt   = 1'b1;
          status_nxt    = pwq_pkg::ST_OK;
          woken_id_nxt  = '0;
          woken_vld_nxt = 1'b0;
          last_nxt      = 1'b1;
          state_nxt     = S_IDLE;
          case (cmd_r)
            pwq_pkg::CMD_INSERT, pwq_pkg::CMD_APPEND: begin
              if (any_hit) begin
                status_nxt = pwq_pkg::ST_DUP;
              end else if (full) begin
                status_nxt = pwq_pkg::ST_FULL;
              end else begin
                ctl.ins_we = 1'b1;
                occ_nxt    = occ_r + 1'b1;
              end
            end
            pwq_pkg::CMD_REMOVE: begin
              ctl.by_id = 1'b1;
              if (any_hit) begin
                ctl.rem_we = 1'b1;
                occ_nxt    = occ_r - 1'b1;
              end else begin
                status_nxt = pwq_pkg::ST_NOT_FOUND;
              end
            end
            pwq_pkg::CMD_WAKE_ONE, pwq_pkg::CMD_WAKE_ALL: begin
              if (occ_r == '0) begin
                status_nxt = pwq_pkg::ST_EMPTY;
              end else begin
                ctl.pop       = 1'b1;
                ctl.rem_we    = 1'b1;
                occ_nxt       = occ_r - 1'b1;
                woken_id_nxt  = cell_id[0];
                woken_vld_nxt = 1'b1;
                if (cmd_r == pwq_pkg::CMD_WAKE_ALL && occ_r != CNT_W'(1)) begin
                  last_nxt  = 1'b0;
                  state_nxt = S_EXEC;
                end
              end
            end
            default: ;
          endcase
          count_nxt = occ_nxt;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      occ_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      occ_r     <= occ_nxt;
      out_vld_r <= out_vld_nxt;
    end
    cmd_r       <= cmd_nxt;
    tid_r       <= tid_nxt;
    prio_r      <= prio_nxt;
    status_r    <= status_nxt;
    woken_id_r  <= woken_id_nxt;
    woken_vld_r <= woken_vld_nxt;
    count_r     <= count_nxt;
    last_r      <= last_nxt;
  end

  assign in_req.ready        = (state_r == S_IDLE);
  assign out_rsp.valid       = out_vld_r;
  assign out_rsp.status      = status_r;
  assign out_rsp.woken_id    = woken_id_r;
  assign out_rsp.woken_valid = woken_vld_r;
  assign out_rsp.entry_count = count_r;
  assign out_rsp.last        = last_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r != $past(occ_r)) |->
      (occ_r == $past(occ_r) + 1'b1 || occ_r == $past(occ_r) - 1'b1))
    else $error("occupancy moved by more than one");

  a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == S_EXEC))
    else $error("result written outside execution");

  a_woken_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && woken_vld_r) |-> (status_r == pwq_pkg::ST_OK && count_r < CNT_W'(QUEUE_DEPTH)))
    else $error("woken result with bad status or count");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;

  localparam int DEPTH = 16;
  localparam int ID_W = 6;
  localparam int PRIO_W = 5;
  localparam int CNT_W = 5;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam int RANDOM_REQS = 240;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD = 80;
  localparam int N_DIR = 18;

  typedef struct {
    pwq_pkg::status_t status;
    logic [ID_W-1:0]  woken_id;
    logic             woken_valid;
    logic [CNT_W-1:0] entry_count;
    logic             last;
  } rsp_t;

  typedef struct {
    logic [2:0]        cmd;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    int                reps;
    bit                typed;
    pwq_pkg::status_t  status;
    int                count;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  pwq_req_if #(.ID_BITS(ID_W), .PRIO_BITS(PRIO_W)) req_if ();
  pwq_rsp_if #(.ID_BITS(ID_W), .CNT_W(CNT_W)) rsp_if ();

  priority_wait_queue #(
    .QUEUE_DEPTH(DEPTH),
    .ID_BITS(ID_W),
    .PRIO_BITS(PRIO_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_req(req_if),
    .out_rsp(rsp_if)
  );

  // shadow of the wait queue, head at index 0
  logic [ID_W-1:0]   wq_id [DEPTH];
  logic [PRIO_W-1:0] wq_prio [DEPTH];
  int                wq_cnt = 0;
  rsp_t              pending_rsps [$];
  int                fail_cnt = 0;
  int                rsp_seen = 0;
  int                burst_left = 0;

  dir_row_t dir_tab [N_DIR] = '{
    '{pwq_pkg::CMD_WAKE_ONE, 6'd0,  5'd0,  1, 1'b1, pwq_pkg::ST_EMPTY,     0},
    '{pwq_pkg::CMD_WAKE_ALL, 6'd0,  5'd0,  1, 1'b1, pwq_pkg::ST_EMPTY,     0},
    '{pwq_pkg::CMD_REMOVE,   6'd0,  5'd0,  1, 1'b1, pwq_pkg::ST_NOT_FOUND, 0},
    '{CMD_UNUSED_LO,         6'd0,  5'd0,  1, 1'b1, pwq_pkg::ST_OK,        0},
    '{pwq_pkg::CMD_INSERT,   6'd63, 5'd31, 1, 1'b1, pwq_pkg::ST_OK,        1},
    '{pwq_pkg::CMD_APPEND,   6'd0,  5'd0,  1, 1'b1, pwq_pkg::ST_OK,        2},
    '{pwq_pkg::CMD_INSERT,   6'd42, 5'd0,  1, 1'b0, pwq_pkg::ST_OK,        0},
    '{pwq_pkg::CMD_INSERT,   6'd63, 5'd0,  1, 1'b1, pwq_pkg::ST_DUP,       3},
    '{pwq_pkg::CMD_REMOVE,   6'd0,  5'd31, 1, 1'b1, pwq_pkg::ST_OK,        2},
    '{pwq_pkg::CMD_WAKE_ONE, 6'd0,  5'd0,  1, 1'b0, pwq_pkg::ST_OK,        0},
    '{pwq_pkg::CMD_WAKE_ALL, 6'd0,  5'd0,  1, 1'b0, pwq_pkg::ST_OK,        0},
    '{pwq_pkg::CMD_INSERT,   6'd1,  5'd31, 8, 1'b0, pwq_pkg::ST_OK,        0},
    '{pwq_pkg::CMD_INSERT,   6'd9,  5'd0,  8, 1'b0, pwq_pkg::ST_OK,        0},
    '{pwq_pkg::CMD_INSERT,   6'd40, 5'd16, 1, 1'b1, pwq_pkg::ST_FULL,      16},
    '{pwq_pkg::CMD_APPEND,   6'd41, 5'd16, 1, 1'b1, pwq_pkg::ST_FULL,      16},
    '{pwq_pkg::CMD_APPEND,   6'd1,  5'd3,  1, 1'b1, pwq_pkg::ST_DUP,       16},
    '{CMD_UNUSED_HI,         6'd63, 5'd31, 1, 1'b1, pwq_pkg::ST_OK,        16},
    '{pwq_pkg::CMD_WAKE_ALL, 6'd0,  5'd0,  1, 1'b0, pwq_pkg::ST_OK,        0}
  };

  function automatic int locate_id(logic [ID_W-1:0] id);
    for (int i = 0; i < wq_cnt; i++)
      if (wq_id[i] == id) return i;
    return wq_cnt;
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < wq_cnt; i++) begin
      wq_id[i]   = wq_id[i+1];
      wq_prio[i] = wq_prio[i+1];
    end
    wq_cnt--;
  endfunction

  function automatic rsp_t mk_rsp(pwq_pkg::status_t st, logic [ID_W-1:0] id,
                                  logic vld, logic lst);
    rsp_t r;
    r.status      = st;
    r.woken_id    = id;
    r.woken_valid = vld;
    r.entry_count = CNT_W'(wq_cnt);
    r.last        = lst;
    return r;
  endfunction

  function automatic void apply_queue_cmd(logic [2:0] c, logic [ID_W-1:0] id,
                                          logic [PRIO_W-1:0] pr, bit record);
    rsp_t            res [$];
    int              pos;
    logic [ID_W-1:0] head;
    case (c)
      pwq_pkg::CMD_INSERT, pwq_pkg::CMD_APPEND: begin
        if (locate_id(id) < wq_cnt) begin
          res.push_back(mk_rsp(pwq_pkg::ST_DUP, '0, 1'b0, 1'b1));
        end else if (wq_cnt >= DEPTH) begin
          res.push_back(mk_rsp(pwq_pkg::ST_FULL, '0, 1'b0, 1'b1));
        end else begin
          pos = wq_cnt;
          // equal priorities stay in arrival order
          if (c == pwq_pkg::CMD_INSERT)
            while (pos > 0 && wq_prio[pos-1] > pr) pos--;
          for (int i = wq_cnt; i > pos; i--) begin
            wq_id[i]   = wq_id[i-1];
            wq_prio[i] = wq_prio[i-1];
          end
          wq_id[pos]   = id;
          wq_prio[pos] = pr;
          wq_cnt++;
          res.push_back(mk_rsp(pwq_pkg::ST_OK, '0, 1'b0, 1'b1));
        end
      end
      pwq_pkg::CMD_REMOVE: begin
        pos = locate_id(id);
        if (pos >= wq_cnt) begin
          res.push_back(mk_rsp(pwq_pkg::ST_NOT_FOUND, '0, 1'b0, 1'b1));
        end else begin
          drop_entry(pos);
          res.push_back(mk_rsp(pwq_pkg::ST_OK, '0, 1'b0, 1'b1));
        end
      end
      pwq_pkg::CMD_WAKE_ONE, pwq_pkg::CMD_WAKE_ALL: begin
        if (wq_cnt == 0) begin
          res.push_back(mk_rsp(pwq_pkg::ST_EMPTY, '0, 1'b0, 1'b1));
        end else begin
          do begin
            head = wq_id[0];
            drop_entry(0);
            res.push_back(mk_rsp(pwq_pkg::ST_OK, head, 1'b1,
                                 (wq_cnt == 0 || c == pwq_pkg::CMD_WAKE_ONE)));
          end while (c == pwq_pkg::CMD_WAKE_ALL && wq_cnt > 0);
        end
      end
      default: res.push_back(mk_rsp(pwq_pkg::ST_OK, '0, 1'b0, 1'b1));
    endcase
    if (record)
      foreach (res[i]) pending_rsps.push_back(res[i]);
  endfunction

  task automatic offer_req(logic [2:0] c, logic [ID_W-1:0] id, logic [PRIO_W-1:0] pr,
                           bit typed, pwq_pkg::status_t st, int cnt);
    int   gap;
    rsp_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_if.valid        <= 1'b1;
    req_if.cmd          <= c;
    req_if.thread_id    <= id;
    req_if.priority_req <= pr;
    do @(posedge clk); while (!req_if.ready);
    apply_queue_cmd(c, id, pr, !typed);
    if (typed) begin
      r = mk_rsp(st, '0, 1'b0, 1'b1);
      r.entry_count = CNT_W'(cnt);
      pending_rsps.push_back(r);
    end
    @(negedge clk);
  endtask

  task automatic quiesce();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (pending_rsps.size() != 0);
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsps.size() == 0) begin
        $error("unexpected result: status %0d, woken_id %0d", rsp_if.status, rsp_if.woken_id);
        fail_cnt++;
      end else begin
        want = pending_rsps.pop_front();
        check_field("status", 8'(want.status), 8'(rsp_if.status));
        check_field("woken_id", 8'(want.woken_id), 8'(rsp_if.woken_id));
        check_field("woken_valid", 8'(want.woken_valid), 8'(rsp_if.woken_valid));
        check_field("entry_count", 8'(want.entry_count), 8'(rsp_if.entry_count));
        check_field("last", 8'(want.last), 8'(rsp_if.last));
        rsp_seen++;
      end
    end
  end

  // result side: stall patterns, plus one long hold-off to back up the queue
  initial begin
    int  mode;
    int  span;
    bit  held;
    held = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      if (!held && rsp_seen >= 60) begin
        held = 1'b1;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          rsp_if.ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 50);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= 1'($urandom_range(0, 1));
          2:       rsp_if.ready <= (k % 3 == 0);
          default: rsp_if.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    int               sent;
    int               r;
    int               id_span;
    bit               fill_mode;
    bit               paused;
    logic [2:0]       c;
    logic [ID_W-1:0]  id;
    logic [PRIO_W-1:0] pr;
    req_if.valid        = 1'b0;
    req_if.cmd          = '0;
    req_if.thread_id    = '0;
    req_if.priority_req = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i])
      for (int k = 0; k < dir_tab[i].reps; k++)
        offer_req(dir_tab[i].cmd, ID_W'(dir_tab[i].id + k), dir_tab[i].prio,
                  dir_tab[i].typed, dir_tab[i].status, dir_tab[i].count);

    sent = 0;
    paused = 1'b0;
    id_span = 63;
    fill_mode = 1'b1;
    while (sent < RANDOM_REQS) begin
      if (sent % 40 == 0) begin
        id_span   = ($urandom_range(0, 1) == 0) ? 20 : 63;
        fill_mode = ((sent / 40) % 2 == 0);
      end
      if (!paused && sent == RANDOM_REQS / 2) begin
        paused = 1'b1;
        quiesce();
      end
      r = $urandom_range(0, 99);
      if (fill_mode) r = r * 6 / 10;
      id = ID_W'($urandom_range(0, id_span));
      pr = ($urandom_range(0, 2) == 0) ? PRIO_W'($urandom_range(0, 3))
                                        : PRIO_W'($urandom_range(0, 31));
      if (r < 38) begin
        c = pwq_pkg::CMD_INSERT;
      end else if (r < 55) begin
        c = pwq_pkg::CMD_APPEND;
      end else if (r < 75) begin
        c = pwq_pkg::CMD_REMOVE;
        if (wq_cnt > 0 && $urandom_range(0, 3) != 0)
          id = wq_id[$urandom_range(0, wq_cnt - 1)];
        else
          id = ID_W'($urandom_range(0, 63));
      end else if (r < 88) begin
        c = pwq_pkg::CMD_WAKE_ONE;
      end else if (r < 92) begin
        c = pwq_pkg::CMD_WAKE_ALL;
      end else if (r < 96) begin
        c = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      end else begin
        c  = 3'($urandom_range(0, 7));
        id = ID_W'($urandom_range(0, 63));
      end
      offer_req(c, id, pr, 1'b0, pwq_pkg::ST_OK, 0);
      if (c <= pwq_pkg::CMD_WAKE_ALL) sent++;
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
